/* hdl/tdms_pkg.sv */
// Package for the melody sequencer: payload words, codes and microcode ROM.
package tdms_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  entry_address;
    logic [15:0] note_freq;
    logic [15:0] note_duration;
  } in_word_t;

  typedef struct packed {
    logic [19:0] pwm_period;
    logic [18:0] pwm_compare;
    logic        pwm_running;
    logic        note_changed;
    logic        song_finished;
  } res_word_t;

  localparam logic REG_NOTE_COUNT = 1'b0;
  localparam logic REG_FAST_INDEX = 1'b1;

  localparam logic [8:0]  NOTE_COUNT_RESET = 9'd1;
  localparam logic [7:0]  FAST_INDEX_RESET = 8'd20;
  localparam logic [19:0] PERIOD_NUM       = 20'd1000000;
  localparam logic [4:0]  DIV_BITS         = 5'd20;

  typedef enum logic [3:0] {
    A_NONE,
    A_ACCEPT,
    A_CTRL,
    A_WRITE,
    A_READ,
    A_FETCH,
    A_DIVSTEP,
    A_SETPWM,
    A_REST,
    A_ADVANCE,
    A_DEC,
    A_EMIT
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_OP_TICK,
    C_OP_LOAD,
    C_NOT_PLAYING,
    C_TICKS_NZ,
    C_FREQ_ZERO,
    C_DIV_MORE
  } cond_e;

  typedef logic [3:0] step_t;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } uc_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_DISP  = 4'd1;
  localparam step_t S_DISP2 = 4'd2;
  localparam step_t S_CTRL  = 4'd3;
  localparam step_t S_LOAD  = 4'd4;
  localparam step_t S_TICK  = 4'd5;
  localparam step_t S_CHK   = 4'd6;
  localparam step_t S_READ  = 4'd7;
  localparam step_t S_FETCH = 4'd8;
  localparam step_t S_FZ    = 4'd9;
  localparam step_t S_DIV   = 4'd10;
  localparam step_t S_SET   = 4'd11;
  localparam step_t S_REST  = 4'd12;
  localparam step_t S_ADV   = 4'd13;
  localparam step_t S_DEC   = 4'd14;
  localparam step_t S_EMIT  = 4'd15;

  function automatic uc_t ucode(step_t pc);
    uc_t w;
    case (pc)
      S_IDLE:  w = '{A_ACCEPT,  C_NO_START,    S_IDLE};
      S_DISP:  w = '{A_NONE,    C_OP_TICK,     S_TICK};
      S_DISP2: w = '{A_NONE,    C_OP_LOAD,     S_LOAD};
      S_CTRL:  w = '{A_CTRL,    C_ALWAYS,      S_EMIT};
      S_LOAD:  w = '{A_WRITE,   C_ALWAYS,      S_EMIT};
      S_TICK:  w = '{A_NONE,    C_NOT_PLAYING, S_EMIT};
      S_CHK:   w = '{A_NONE,    C_TICKS_NZ,    S_DEC};
      S_READ:  w = '{A_READ,    C_NEVER,       S_IDLE};
      S_FETCH: w = '{A_FETCH,   C_NEVER,       S_IDLE};
      S_FZ:    w = '{A_NONE,    C_FREQ_ZERO,   S_REST};
      S_DIV:   w = '{A_DIVSTEP, C_DIV_MORE,    S_DIV};
      S_SET:   w = '{A_SETPWM,  C_ALWAYS,      S_ADV};
      S_REST:  w = '{A_REST,    C_NEVER,       S_IDLE};
      S_ADV:   w = '{A_ADVANCE, C_ALWAYS,      S_EMIT};
      S_DEC:   w = '{A_DEC,     C_ALWAYS,      S_EMIT};
      S_EMIT:  w = '{A_EMIT,    C_ALWAYS,      S_IDLE};
      default: w = '{A_NONE,    C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* hdl/tdms_ram.sv */
// Generic single-port-write, registered-read RAM.
module tdms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tick_driven_melody_sequencer_unit.sv */
// Melody sequencer for a PWM buzzer: microcoded control over a note table.
// Usage: load the table with load words (op 1), then send a start word (op 2)
// and one tick word (op 0) per millisecond; op 3 stops playback.
// A word is taken when start is high and busy is low; busy stays high until
// the result word has been shown. Each word yields exactly one result word,
// valid for one cycle with res_valid_o; the receiver cannot stall it.
// Steps from acceptance to EMIT. Load, start, stop: DISP, DISP2, LOAD or
//   CTRL; idle tick: DISP, TICK; countdown tick: DISP, TICK, CHK, DEC; note
//   tick: DISP, TICK, CHK, READ, FETCH, FZ, then REST or, for a tone, the
//   restoring divider (one quotient bit per cycle, 20 bits) computing
//   1000000/freq, then SET; both then ADV. busy drops the cycle after EMIT.
// The note table is a registered-read RAM, read in READ ahead of use in FETCH.
// Registers (APB): 0x0 note_count, 0x4 fast_index; write only while idle.
// Reset clears playback state, PWM values and the sequencer; the table is
// not cleared and holds garbage until written.
module tick_driven_melody_sequencer_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tdms_pkg::in_word_t  in_i,
  output logic                res_valid_o,
  output tdms_pkg::res_word_t res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = (AW > 9) ? AW : 9;

  tdms_pkg::step_t    pc_q, pc_d;
  tdms_pkg::uc_t      uw;
  tdms_pkg::in_word_t in_q, in_d;
  logic [8:0]  count_q, count_d;
  logic [7:0]  fast_q, fast_d;
  logic [8:0]  pos_q, pos_d, pos_inc;
  logic [15:0] ticks_q, ticks_d;
  logic        playing_q, playing_d;
  logic [19:0] period_q, period_d;
  logic [18:0] compare_q, compare_d;
  logic        changed_q, changed_d;
  logic        finished_q, finished_d;
  logic [15:0] freq_q, freq_d;
  logic [15:0] rem_q, rem_d;
  logic [19:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] trial;
  logic        take;
  logic        cond_ok;
  logic        cfg_we;
  logic        pos_ok, wr_ok;
  logic [XW-1:0] pos_x, waddr_x;
  logic        ram_we;
  logic [31:0] ram_rdata;

  assign uw = tdms_pkg::ucode(pc_q);

  assign pos_x   = XW'(pos_q);
  assign waddr_x = XW'(in_q.entry_address);
  assign pos_ok  = {1'b0, pos_x} < (XW+1)'(TABLE_DEPTH);
  assign wr_ok   = {1'b0, waddr_x} < (XW+1)'(TABLE_DEPTH);
  assign ram_we  = (uw.act == tdms_pkg::A_WRITE) && wr_ok;

  tdms_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_x[AW-1:0]),
    .wdata_i ({in_q.note_freq, in_q.note_duration}),
    .raddr_i (pos_x[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    case (uw.cond)
      tdms_pkg::C_NEVER:       cond_ok = 1'b0;
      tdms_pkg::C_ALWAYS:      cond_ok = 1'b1;
      tdms_pkg::C_NO_START:    cond_ok = !start;
      tdms_pkg::C_OP_TICK:     cond_ok = in_q.op == tdms_pkg::OP_TICK;
      tdms_pkg::C_OP_LOAD:     cond_ok = in_q.op == tdms_pkg::OP_LOAD;
      tdms_pkg::C_NOT_PLAYING: cond_ok = !playing_q;
      tdms_pkg::C_TICKS_NZ:    cond_ok = ticks_q != 16'd0;
      tdms_pkg::C_FREQ_ZERO:   cond_ok = freq_q == 16'd0;
      tdms_pkg::C_DIV_MORE:    cond_ok = cnt_q != 5'd1;
      default:                 cond_ok = 1'b0;
    endcase
    pc_d = cond_ok ? uw.target : pc_q + 4'd1;
  end

  assign trial   = {rem_q, quo_q[19]};
  assign pos_inc = pos_q + 9'd1;
  assign take    = trial >= {1'b0, freq_q};

  // datapath
  always_comb begin
    in_d       = in_q;
    pos_d      = pos_q;
    ticks_d    = ticks_q;
    playing_d  = playing_q;
    period_d   = period_q;
    compare_d  = compare_q;
    changed_d  = changed_q;
    finished_d = finished_q;
    freq_d     = freq_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    case (uw.act)
      tdms_pkg::A_ACCEPT: begin
        in_d       = in_i;
        changed_d  = 1'b0;
        finished_d = 1'b0;
      end
      tdms_pkg::A_CTRL: begin
        playing_d = in_q.op == tdms_pkg::OP_START;
        pos_d     = '0;
        ticks_d   = '0;
      end
      tdms_pkg::A_FETCH: begin
        freq_d    = pos_ok ? ram_rdata[31:16] : 16'd0;
        ticks_d   = pos_ok ? ram_rdata[15:0] : 16'd0;
        rem_d     = '0;
        quo_d     = tdms_pkg::PERIOD_NUM;
        cnt_d     = tdms_pkg::DIV_BITS;
        changed_d = 1'b1;
      end
      tdms_pkg::A_DIVSTEP: begin
        rem_d = take ? 16'(trial - {1'b0, freq_q}) : trial[15:0];
        quo_d = {quo_q[18:0], take};
        cnt_d = cnt_q - 5'd1;
      end
      tdms_pkg::A_SETPWM: begin
        period_d  = quo_q;
        compare_d = quo_q[19:1];
      end
      tdms_pkg::A_REST: begin
        period_d = '0;
      end
      tdms_pkg::A_ADVANCE: begin
        if (pos_inc >= count_q || pos_inc == 9'd0) begin
          playing_d  = 1'b0;
          pos_d      = '0;
          finished_d = 1'b1;
        end else begin
          pos_d = pos_inc;
        end
      end
      tdms_pkg::A_DEC: begin
        if (pos_q == {1'b0, fast_q} && ticks_q > 16'd1) begin
          ticks_d = ticks_q - 16'd2;
        end else begin
          ticks_d = ticks_q - 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // config port
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    count_d = count_q;
    fast_d  = fast_q;
    if (cfg_we) begin
      if (paddr[2] == tdms_pkg::REG_NOTE_COUNT) begin
        count_d = pwdata[8:0];
      end else begin
        fast_d = pwdata[7:0];
      end
    end
    prdata = (paddr[2] == tdms_pkg::REG_FAST_INDEX) ? {24'd0, fast_q} : {23'd0, count_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= tdms_pkg::S_IDLE;
      count_q    <= tdms_pkg::NOTE_COUNT_RESET;
      fast_q     <= tdms_pkg::FAST_INDEX_RESET;
      pos_q      <= '0;
      ticks_q    <= '0;
      playing_q  <= 1'b0;
      period_q   <= '0;
      compare_q  <= '0;
      changed_q  <= 1'b0;
      finished_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      pc_q       <= pc_d;
      count_q    <= count_d;
      fast_q     <= fast_d;
      pos_q      <= pos_d;
      ticks_q    <= ticks_d;
      playing_q  <= playing_d;
      period_q   <= period_d;
      compare_q  <= compare_d;
      changed_q  <= changed_d;
      finished_q <= finished_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    freq_q <= freq_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign busy        = pc_q != tdms_pkg::S_IDLE;
  assign res_valid_o = uw.act == tdms_pkg::A_EMIT;
  assign res_o       = '{pwm_period:    period_q,
                         pwm_compare:   compare_q,
                         pwm_running:   playing_q,
                         note_changed:  changed_q,
                         song_finished: finished_q};

endmodule

/* hdl/tdms_chk.sv */
// Port-level checker for the melody sequencer, bound to the top level.
module tdms_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                res_valid_o,
  input tdms_pkg::res_word_t res_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted word");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o && !busy)
    else $error("result not followed by idle");

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result shown while not busy");

  a_fin_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.song_finished |-> !res_o.pwm_running && res_o.note_changed)
    else $error("finished song still running");

endmodule

bind tick_driven_melody_sequencer_unit tdms_chk u_tdms_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
